FILE: design/ftfd_pkg.sv
package ftfd_pkg;

  // Depth of the command queue between the parser and the tracker.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Header pattern and tail bytes of a frame.
  localparam logic [7:0] HDR_BYTE0 = 8'h0F;
  localparam logic [7:0] HDR_BYTE1 = 8'hF0;
  localparam logic [7:0] HDR_BYTE2 = 8'h00;
  localparam logic [7:0] HDR_BYTE3 = 8'hFF;
  localparam logic [7:0] TAIL_CR   = 8'h0D;
  localparam logic [7:0] TAIL_LF   = 8'h0A;

  // Frame types understood by the tracker.
  localparam logic [7:0] TYPE_START  = 8'd1;
  localparam logic [7:0] TYPE_DATA   = 8'd2;
  localparam logic [7:0] TYPE_END    = 8'd3;
  localparam logic [7:0] TYPE_CANCEL = 8'd4;

  // Reply codes.
  localparam logic [2:0] RC_NONE      = 3'd0;
  localparam logic [2:0] RC_START_ACK = 3'd1;
  localparam logic [2:0] RC_END_ACK   = 3'd3;
  localparam logic [2:0] RC_CANCEL    = 3'd4;

  // A start frame is taken only with at least this many payload bytes; the file size is in the first four.
  localparam logic [15:0] START_MIN_LEN = 16'd5;

  localparam logic [6:0] PCT_FULL = 7'd100;

  // One command handed from the parser to the tracker.
  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  data;
    logic [7:0]  ftype;
    logic        ok;
    logic [15:0] length;
    logic [31:0] size;
  } cmd_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = HDR_BYTE0;
      2'd1: b = HDR_BYTE1;
      2'd2: b = HDR_BYTE2;
      2'd3: b = HDR_BYTE3;
      default: b = HDR_BYTE0;
    endcase
    return b;
  endfunction

endpackage

FILE: design/ftfd_front.sv
module ftfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              full_i,
  output logic              push_o,
  output ftfd_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_TYPE, PH_PAYLOAD, PH_TAIL_A, PH_TAIL_B
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] idx_q, idx_d;
  logic [31:0] size_q, size_d;
  logic        tail_seen_q, tail_seen_d;
  logic        accept;
  logic [15:0] idx_inc;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign idx_inc    = idx_q + 16'd1;

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    len_d       = len_q;
    type_d      = type_q;
    idx_d       = idx_q;
    size_d      = size_q;
    tail_seen_d = tail_seen_q;
    push_o      = 1'b0;
    cmd_o.is_verdict = 1'b0;
    cmd_o.data       = rx_byte_i;
    cmd_o.ftype      = type_q;
    cmd_o.ok         = 1'b0;
    cmd_o.length     = len_q;
    cmd_o.size       = size_q;
    if (accept) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == ftfd_pkg::hdr_byte(hdr_cnt_q)) begin
            if (hdr_cnt_q == 2'd3) begin
              hdr_cnt_d = 2'd0;
              phase_d   = PH_LEN_HI;
            end else begin
              hdr_cnt_d = hdr_cnt_q + 2'd1;
            end
          end else begin
            hdr_cnt_d = (rx_byte_i == ftfd_pkg::HDR_BYTE0) ? 2'd1 : 2'd0;
          end
        end
        PH_LEN_HI: begin
          len_d   = {rx_byte_i, 8'h00};
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d   = {len_q[15:8], rx_byte_i};
          phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          type_d      = rx_byte_i;
          idx_d       = 16'd0;
          size_d      = 32'd0;
          tail_seen_d = 1'b0;
          phase_d     = (len_q == 16'd0) ? PH_TAIL_A : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (idx_q < 16'd4) begin
            size_d = {size_q[23:0], rx_byte_i};
          end
          idx_d = idx_inc;
          if (idx_inc >= len_q) begin
            phase_d = PH_TAIL_A;
          end
          push_o = 1'b1;
        end
        PH_TAIL_A: begin
          tail_seen_d = (rx_byte_i == ftfd_pkg::TAIL_CR);
          phase_d     = PH_TAIL_B;
        end
        PH_TAIL_B: begin
          push_o           = 1'b1;
          cmd_o.is_verdict = 1'b1;
          cmd_o.ok         = tail_seen_q && (rx_byte_i == ftfd_pkg::TAIL_LF);
          tail_seen_d      = 1'b0;
          hdr_cnt_d        = 2'd0;
          phase_d          = PH_HUNT;
        end
        default: begin
          hdr_cnt_d = 2'd0;
          phase_d   = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      hdr_cnt_q   <= 2'd0;
      len_q       <= 16'd0;
      type_q      <= 8'd0;
      idx_q       <= 16'd0;
      size_q      <= 32'd0;
      tail_seen_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      len_q       <= len_d;
      type_q      <= type_d;
      idx_q       <= idx_d;
      size_q      <= size_d;
      tail_seen_q <= tail_seen_d;
    end
  end

endmodule

FILE: design/ftfd_queue.sv
module ftfd_queue #(
  parameter int unsigned Depth = ftfd_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ftfd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output ftfd_pkg::cmd_t cmd_o,
  output logic           valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ftfd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: design/ftfd_back.sv
module ftfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  ftfd_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           out_kind_o,
  output logic [7:0]     payload_byte_o,
  output logic [7:0]     frame_type_o,
  output logic           frame_ok_o,
  output logic [2:0]     reply_code_o,
  output logic           reply_flag_o,
  output logic           progress_valid_o,
  output logic [6:0]     progress_percent_o,
  output logic           transfer_done_o,
  output logic [31:0]    announced_size_o
);

  typedef enum logic [1:0] { B_IDLE, B_MUL, B_DIV, B_EMIT } state_e;

  state_e      state_q, state_d;
  logic [31:0] fs_q, fs_d;
  logic [33:0] rcv_q, rcv_d;
  logic        open_q, open_d;
  logic [38:0] num_q, num_d;
  logic [38:0] dsh_q, dsh_d;
  logic [6:0]  quot_q, quot_d;
  logic [2:0]  step_q, step_d;
  logic        ov_q, ov_d;
  logic        kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  type_q, type_d;
  logic        ok_q, ok_d;
  logic [2:0]  reply_q, reply_d;
  logic        flag_q, flag_d;
  logic        pv_q, pv_d;
  logic [6:0]  pct_q, pct_d;
  logic        done_q, done_d;
  logic        out_free;
  logic [33:0] rcv_sum;

  assign out_free = !ov_q || !out_stall_i;
  assign rcv_sum  = rcv_q + {18'd0, cmd_i.length};

  always_comb begin
    state_d = state_q;
    fs_d    = fs_q;
    rcv_d   = rcv_q;
    open_d  = open_q;
    num_d   = num_q;
    dsh_d   = dsh_q;
    quot_d  = quot_q;
    step_d  = step_q;
    ov_d    = (ov_q && out_stall_i);
    kind_d  = kind_q;
    byte_d  = byte_q;
    type_d  = type_q;
    ok_d    = ok_q;
    reply_d = reply_q;
    flag_d  = flag_q;
    pv_d    = pv_q;
    pct_d   = pct_q;
    done_d  = done_q;
    pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i && out_free) begin
          pop_o   = 1'b1;
          ov_d    = 1'b1;
          kind_d  = cmd_i.is_verdict;
          byte_d  = cmd_i.is_verdict ? 8'd0 : cmd_i.data;
          type_d  = cmd_i.ftype;
          ok_d    = cmd_i.is_verdict && cmd_i.ok;
          reply_d = ftfd_pkg::RC_NONE;
          flag_d  = 1'b0;
          pv_d    = 1'b0;
          pct_d   = 7'd0;
          done_d  = 1'b0;
          if (cmd_i.is_verdict && cmd_i.ok) begin
            case (cmd_i.ftype)
              ftfd_pkg::TYPE_START: begin
                open_d = 1'b0;
                if (cmd_i.length >= ftfd_pkg::START_MIN_LEN) begin
                  fs_d    = cmd_i.size;
                  rcv_d   = 34'd0;
                  open_d  = 1'b1;
                  reply_d = ftfd_pkg::RC_START_ACK;
                end
              end
              ftfd_pkg::TYPE_DATA: begin
                if (!open_q) begin
                  reply_d = ftfd_pkg::RC_CANCEL;
                end else begin
                  rcv_d = rcv_sum;
                  pv_d  = 1'b1;
                  if (rcv_sum >= {2'b00, fs_q}) begin
                    open_d = 1'b0;
                    done_d = 1'b1;
                    pct_d  = ftfd_pkg::PCT_FULL;
                  end else begin
                    // Result is held back until the percentage is worked out.
                    ov_d    = 1'b0;
                    state_d = B_MUL;
                  end
                end
              end
              ftfd_pkg::TYPE_END: begin
                open_d  = 1'b0;
                reply_d = ftfd_pkg::RC_END_ACK;
                flag_d  = (rcv_q == {2'b00, fs_q});
              end
              ftfd_pkg::TYPE_CANCEL: begin
                open_d = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end
      B_MUL: begin
        // The count is below the file size here, so it fits in 32 bits.
        num_d   = 39'(rcv_q[31:0]) * 39'd100;
        dsh_d   = {1'b0, fs_q, 6'd0};
        quot_d  = 7'd0;
        step_d  = 3'd6;
        state_d = B_DIV;
      end
      B_DIV: begin
        if (num_q >= dsh_q) begin
          num_d  = num_q - dsh_q;
          quot_d = quot_q | (7'd1 << step_q);
        end
        dsh_d = dsh_q >> 1;
        if (step_q == 3'd0) begin
          state_d = B_EMIT;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          pct_d   = quot_q;
          ov_d    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      fs_q    <= 32'd0;
      rcv_q   <= 34'd0;
      open_q  <= 1'b0;
      num_q   <= 39'd0;
      dsh_q   <= 39'd0;
      quot_q  <= 7'd0;
      step_q  <= 3'd0;
      ov_q    <= 1'b0;
      kind_q  <= 1'b0;
      byte_q  <= 8'd0;
      type_q  <= 8'd0;
      ok_q    <= 1'b0;
      reply_q <= ftfd_pkg::RC_NONE;
      flag_q  <= 1'b0;
      pv_q    <= 1'b0;
      pct_q   <= 7'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fs_q    <= fs_d;
      rcv_q   <= rcv_d;
      open_q  <= open_d;
      num_q   <= num_d;
      dsh_q   <= dsh_d;
      quot_q  <= quot_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
      kind_q  <= kind_d;
      byte_q  <= byte_d;
      type_q  <= type_d;
      ok_q    <= ok_d;
      reply_q <= reply_d;
      flag_q  <= flag_d;
      pv_q    <= pv_d;
      pct_q   <= pct_d;
      done_q  <= done_d;
    end
  end

  // The file size only changes when a new result is loaded, so it can be
  // shown directly with every result.
  assign out_valid_o        = ov_q;
  assign out_kind_o         = kind_q;
  assign payload_byte_o     = byte_q;
  assign frame_type_o       = type_q;
  assign frame_ok_o         = ok_q;
  assign reply_code_o       = reply_q;
  assign reply_flag_o       = flag_q;
  assign progress_valid_o   = pv_q;
  assign progress_percent_o = pct_q;
  assign transfer_done_o    = done_q;
  assign announced_size_o   = fs_q;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> pct_q <= ftfd_pkg::PCT_FULL)
    else $error("progress above full scale");

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && done_q |-> pv_q && pct_q == ftfd_pkg::PCT_FULL && reply_q == ftfd_pkg::RC_NONE)
    else $error("completion without full progress");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !kind_q |-> !ok_q && reply_q == ftfd_pkg::RC_NONE && !pv_q && !done_q)
    else $error("payload result carries verdict fields");

  a_mul_then_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_MUL |=> state_q == B_DIV && !ov_q)
    else $error("division did not follow the product");

endmodule

FILE: design/file_transfer_frame_deframer.sv
// Channel  | Handshake                    | Fields
// ---------+------------------------------+---------------------------------------------
// input    | in_valid_i / in_stall_o      | rx_byte_i
// output   | out_valid_o / out_stall_i    | out_kind_o, payload_byte_o, frame_type_o,
//          |                              | frame_ok_o, reply_code_o, reply_flag_o,
//          |                              | progress_valid_o, progress_percent_o,
//          |                              | transfer_done_o, announced_size_o
//
// The parser takes one byte every cycle while its command queue has room.
// A payload byte or a verdict is loaded into the output register at the edge
// that takes it from the queue, where the parser wrote it once the byte that
// caused it was accepted. A data frame that needs a progress figure holds the
// tracker for the load, one multiply, seven restoring divide steps and the
// final load of the percentage, which is what limits the sustained rate on
// short data frames.
// Reset clears the parser, the queue pointers, the tracker and the output
// valid at once; there is no clearing pass.
// A stall on the output holds the result register and backs up the queue,
// and the input is stalled only when the queue is full.
module file_transfer_frame_deframer #(
  parameter int unsigned QueueDepth = ftfd_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  frame_type_o,
  output logic        frame_ok_o,
  output logic [2:0]  reply_code_o,
  output logic        reply_flag_o,
  output logic        progress_valid_o,
  output logic [6:0]  progress_percent_o,
  output logic        transfer_done_o,
  output logic [31:0] announced_size_o
);

  // Commands flow from the parser through the queue to the tracker. Each
  // command is either a payload byte or an end-of-frame verdict that carries
  // everything the tracker needs: type, length and the leading size bytes.
  ftfd_pkg::cmd_t push_cmd, pop_cmd;
  logic           push, full, pop, cmd_valid;

  ftfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ftfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .valid_o (cmd_valid)
  );

  // The tracker owns the transfer state and the output register. The
  // progress percentage is found with a bit-per-cycle restoring divider,
  // which only ever needs seven quotient bits because the count is below
  // the file size whenever a division is needed.
  ftfd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (cmd_valid),
    .cmd_i              (pop_cmd),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_kind_o         (out_kind_o),
    .payload_byte_o     (payload_byte_o),
    .frame_type_o       (frame_type_o),
    .frame_ok_o         (frame_ok_o),
    .reply_code_o       (reply_code_o),
    .reply_flag_o       (reply_flag_o),
    .progress_valid_o   (progress_valid_o),
    .progress_percent_o (progress_percent_o),
    .transfer_done_o    (transfer_done_o),
    .announced_size_o   (announced_size_o)
  );

endmodule
